>>> src/assert_macros.svh
// Assertion macros for the RTL of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while the reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same, for a property that must also hold while the reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> src/srei_pkg.sv
`timescale 1ns / 1ps

package srei_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } srei_point_t;

  // Load enables of the three payload stages inside an edge unit.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } srei_adv_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 3'd0,
    REG_BOTTOM = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_TOP    = 3'd3
  } srei_reg_e;

  typedef enum logic [1:0] {
    ORIENT_COLL = 2'd0,
    ORIENT_CW   = 2'd1,
    ORIENT_CCW  = 2'd2
  } srei_orient_e;

endpackage

>>> src/srei_edge.sv
`timescale 1ns / 1ps

module srei_edge (
  input  logic                clk_i,
  input  srei_pkg::srei_adv_t adv_i,
  input  srei_pkg::srei_point_t a_i,
  input  srei_pkg::srei_point_t b_i,
  input  srei_pkg::srei_point_t c_i,
  input  srei_pkg::srei_point_t d_i,
  output logic                cross_o
);
  import srei_pkg::*;

  function automatic diff_t sub_ext(input coord_t x, input coord_t y);
    return {x[COORD_WIDTH-1], x} - {y[COORD_WIDTH-1], y};
  endfunction

  // True when q lies in the bounding box spanned by p and r.
  function automatic logic in_box(input srei_point_t p, input srei_point_t q,
                                  input srei_point_t r);
    logic in_x;
    logic in_y;
    in_x = ($signed(p.x) <= $signed(q.x) && $signed(q.x) <= $signed(r.x)) ||
           ($signed(r.x) <= $signed(q.x) && $signed(q.x) <= $signed(p.x));
    in_y = ($signed(p.y) <= $signed(q.y) && $signed(q.y) <= $signed(r.y)) ||
           ($signed(r.y) <= $signed(q.y) && $signed(q.y) <= $signed(p.y));
    return in_x && in_y;
  endfunction

  function automatic srei_orient_e orient_of(input prod_t m, input prod_t n);
    logic [CROSS_W-1:0] d;
    d = {m[PROD_W-1], m} - {n[PROD_W-1], n};
    if (d == '0) begin
      return ORIENT_COLL;
    end else if (d[CROSS_W-1]) begin
      return ORIENT_CCW;
    end else begin
      return ORIENT_CW;
    end
  endfunction

  srei_point_t  p [4];
  srei_point_t  q [4];
  srei_point_t  r [4];
  diff_t        ma_d [4];
  diff_t        mb_d [4];
  diff_t        na_d [4];
  diff_t        nb_d [4];
  logic [3:0]   w_d;
  diff_t        ma_q [4];
  diff_t        mb_q [4];
  diff_t        na_q [4];
  diff_t        nb_q [4];
  logic [3:0]   w1_q;
  prod_t        m_d [4];
  prod_t        n_d [4];
  prod_t        m_q [4];
  prod_t        n_q [4];
  logic [3:0]   w2_q;
  srei_orient_e o_d [4];
  srei_orient_e o_q [4];
  logic [3:0]   w3_q;

  // The four triplets of the orientation test: (a,b,c), (a,b,d), (c,d,a), (c,d,b).
  always_comb begin
    p[0] = a_i; q[0] = b_i; r[0] = c_i;
    p[1] = a_i; q[1] = b_i; r[1] = d_i;
    p[2] = c_i; q[2] = d_i; r[2] = a_i;
    p[3] = c_i; q[3] = d_i; r[3] = b_i;
    for (int k = 0; k < 4; k++) begin
      ma_d[k] = sub_ext(q[k].y, p[k].y);
      mb_d[k] = sub_ext(r[k].x, q[k].x);
      na_d[k] = sub_ext(q[k].x, p[k].x);
      nb_d[k] = sub_ext(r[k].y, q[k].y);
    end
    w_d[0] = in_box(a_i, c_i, b_i);
    w_d[1] = in_box(a_i, d_i, b_i);
    w_d[2] = in_box(c_i, a_i, d_i);
    w_d[3] = in_box(c_i, b_i, d_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      ma_q <= ma_d;
      mb_q <= mb_d;
      na_q <= na_d;
      nb_q <= nb_d;
      w1_q <= w_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      m_d[k] = ma_q[k] * mb_q[k];
      n_d[k] = na_q[k] * nb_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      m_q  <= m_d;
      n_q  <= n_d;
      w2_q <= w1_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      o_d[k] = orient_of(m_q[k], n_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      o_q  <= o_d;
      w3_q <= w2_q;
    end
  end

  // General case, then the four collinear cases.
  assign cross_o = (o_q[0] != o_q[1] && o_q[2] != o_q[3]) ||
                   (o_q[0] == ORIENT_COLL && w3_q[0]) ||
                   (o_q[1] == ORIENT_COLL && w3_q[1]) ||
                   (o_q[2] == ORIENT_COLL && w3_q[2]) ||
                   (o_q[3] == ORIENT_COLL && w3_q[3]);

endmodule

>>> src/segment_rectangle_edge_intersect.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake                  Payload
// in        request    in_valid_i / in_ready_o    start_x_i, start_y_i, end_x_i, end_y_i
// out       result     out_valid_o / out_ready_i  hit_o
// cfg       write      cfg_valid_i / cfg_ready_o  cfg_idx_i, cfg_data_i
//
// A request passes four registers: difference and box compare, products, orientation
// signs, and the output register holding hit_o. The first loads at the accepting edge,
// and out_valid_o rises once the request has passed the other three.
// One request is accepted per cycle unless the output stalls a full pipeline; the
// 17 x 17 multipliers of the product stage set the clock period.
// The reset clears the valid bits and the rectangle corners; data registers keep junk.
// A stall on the output collapses bubbles first; in_ready_o falls only when every
// stage holds a request and the output is not taken.

module segment_rectangle_edge_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  srei_pkg::coord_t              start_x_i,
  input  srei_pkg::coord_t              start_y_i,
  input  srei_pkg::coord_t              end_x_i,
  input  srei_pkg::coord_t              end_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srei_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  srei_pkg::coord_t              cfg_data_i
);
  import srei_pkg::*;

  coord_t      left_q, bottom_q, right_q, top_q;
  srei_point_t seg_a, seg_b;
  srei_point_t lb, rb, lt, rt;
  srei_adv_t   adv;
  logic        v1_q, v2_q, v3_q, vo_q;
  logic        f1, f2, f3, fo;
  logic [3:0]  edge_cross;
  logic        hit_d, hit_q;

  // Rectangle corners. Writes must land only while the pipeline is empty, so the
  // first stage may read them directly; the block itself does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      bottom_q <= '0;
      right_q  <= '0;
      top_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        REG_LEFT:   left_q   <= cfg_data_i;
        REG_BOTTOM: bottom_q <= cfg_data_i;
        REG_RIGHT:  right_q  <= cfg_data_i;
        REG_TOP:    top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads.
  assign fo = !vo_q || out_ready_i;
  assign f3 = !v3_q || fo;
  assign f2 = !v2_q || f3;
  assign f1 = !v1_q || f2;
  assign in_ready_o = f1;

  assign adv.s1 = f1 && in_valid_i;
  assign adv.s2 = f2 && v1_q;
  assign adv.s3 = f3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (f1) v1_q <= in_valid_i;
      if (f2) v2_q <= v1_q;
      if (f3) v3_q <= v2_q;
      if (fo) vo_q <= v3_q;
    end
  end

  assign seg_a = '{x: start_x_i, y: start_y_i};
  assign seg_b = '{x: end_x_i,   y: end_y_i};
  assign lb    = '{x: left_q,    y: bottom_q};
  assign rb    = '{x: right_q,   y: bottom_q};
  assign lt    = '{x: left_q,    y: top_q};
  assign rt    = '{x: right_q,   y: top_q};

  // Bottom, top, left and right edges of the outline.
  srei_edge u_edge_bottom (
    .clk_i, .adv_i(adv), .a_i(seg_a), .b_i(seg_b), .c_i(lb), .d_i(rb),
    .cross_o(edge_cross[0])
  );
  srei_edge u_edge_top (
    .clk_i, .adv_i(adv), .a_i(seg_a), .b_i(seg_b), .c_i(lt), .d_i(rt),
    .cross_o(edge_cross[1])
  );
  srei_edge u_edge_left (
    .clk_i, .adv_i(adv), .a_i(seg_a), .b_i(seg_b), .c_i(lb), .d_i(lt),
    .cross_o(edge_cross[2])
  );
  srei_edge u_edge_right (
    .clk_i, .adv_i(adv), .a_i(seg_a), .b_i(seg_b), .c_i(rb), .d_i(rt),
    .cross_o(edge_cross[3])
  );

  assign hit_d = |edge_cross;

  always_ff @(posedge clk_i) begin
    if (fo && v3_q) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = vo_q;
  assign hit_o       = hit_q;

  `ASSERT_CLK(a_out_load, (v3_q && fo) |=> out_valid_o,
              "finished request did not reach the output register")
  `ASSERT_CLK(a_full_stall, !in_ready_o |-> (v1_q && v2_q && v3_q && vo_q && !out_ready_i),
              "input stalled while the pipeline still had a bubble")
  `ASSERT_CLK(a_hold_s2, (v2_q && !f3) |=> v2_q,
              "request in the product stage was dropped during a stall")
  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o,
                 "result presented during reset")

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

// Testbench for segment_rectangle_edge_intersect.
//
// The block answers one question per request: does the query segment touch any edge
// of the rectangle held in its corner registers? The testbench keeps
// its own exact predictor of that answer, built on signed 64-bit cross products,
// which is far wider than the 35 bits the products need, so every sign is exact.
//
// Structure:
//   - An initial block plans the run as a series of phases. Each phase after the first
//     programs the rectangle while the block is idle, then queues segment requests.
//   - A clocked driver feeds requests from that queue, with random gaps.
//   - A clocked receiver drops out_ready_i at random to stall the result channel.
//   - A clocked monitor tracks register writes, predicts the hit for each accepted
//     request, and checks every accepted result against the oldest prediction.

module tb;
  import srei_pkg::*;

  // Bound on the whole run.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Drain tail: it waits past the depth of the pipeline up to the result register.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 150;
  // Lowest register index that maps to no corner; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd4;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } segment_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    coord_t               data;
  } reg_write_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b1;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  logic   hit_o;
  logic   cfg_valid_i = 1'b0;
  logic   cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  coord_t cfg_data_i = '0;

  segment_t segment_q[$];
  bit       hit_expected_q[$];
  int       segments_queued = 0;
  int       segments_accepted = 0;
  int       fail_count = 0;
  int unsigned cycle_count = 0;

  // Corner registers as the block should hold them, updated on each write request.
  coord_t corner_left = '0;
  coord_t corner_bottom = '0;
  coord_t corner_right = '0;
  coord_t corner_top = '0;

  // Burst flags switch idling off on one side for a stretch of cycles.
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  segment_rectangle_edge_intersect dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------

  // Turn direction of p -> q -> r, from the sign of the exact cross product.
  function automatic srei_orient_e turn_of(point_t p, point_t q, point_t r);
    longint cross_prod;
    cross_prod = (q.y - p.y) * (r.x - q.x) - (q.x - p.x) * (r.y - q.y);
    if (cross_prod == 0) return ORIENT_COLL;
    return (cross_prod < 0) ? ORIENT_CCW : ORIENT_CW;
  endfunction

  // True when q lies inside the bounding box spanned by p and r.
  function automatic bit in_box(point_t p, point_t q, point_t r);
    return q.x <= ((p.x > r.x) ? p.x : r.x) && q.x >= ((p.x < r.x) ? p.x : r.x) &&
           q.y <= ((p.y > r.y) ? p.y : r.y) && q.y >= ((p.y < r.y) ? p.y : r.y);
  endfunction

  // Segment a-b against segment c-d. The general case needs both pairs of turns to
  // differ; a collinear turn falls back to the bounding-box test, which also covers
  // zero-length segments.
  function automatic bit segments_meet(point_t a, point_t b, point_t c, point_t d);
    srei_orient_e o1, o2, o3, o4;
    o1 = turn_of(a, b, c);
    o2 = turn_of(a, b, d);
    o3 = turn_of(c, d, a);
    o4 = turn_of(c, d, b);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == ORIENT_COLL && in_box(a, c, b)) return 1'b1;
    if (o2 == ORIENT_COLL && in_box(a, d, b)) return 1'b1;
    if (o3 == ORIENT_COLL && in_box(c, a, d)) return 1'b1;
    if (o4 == ORIENT_COLL && in_box(c, b, d)) return 1'b1;
    return 1'b0;
  endfunction

  // Expected hit for one segment against the outline held in the corner registers.
  // Unordered corners need no special handling: the edges are the same.
  function automatic bit segment_hits_outline(segment_t seg);
    point_t s, e, lb, rb, lt, rt;
    s = '{longint'(seg.sx), longint'(seg.sy)};
    e = '{longint'(seg.ex), longint'(seg.ey)};
    lb = '{longint'(corner_left), longint'(corner_bottom)};
    rb = '{longint'(corner_right), longint'(corner_bottom)};
    lt = '{longint'(corner_left), longint'(corner_top)};
    rt = '{longint'(corner_right), longint'(corner_top)};
    return segments_meet(s, e, lb, rb) || segments_meet(s, e, lt, rt) ||
           segments_meet(s, e, lb, lt) || segments_meet(s, e, rb, rt);
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long, never during a burst.
  function automatic int idle_length(bit burst);
    int unsigned roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coord_t'(v);
  endfunction

  // One coordinate on an axis whose rectangle edges sit at a and b. Most picks land
  // on, next to, or between the edges, so that touching and collinear cases are common.
  function automatic coord_t pick_coord(coord_t a, coord_t b);
    int unsigned roll;
    longint lo, hi;
    roll = $urandom_range(0, 9);
    lo = (a < b) ? longint'(a) : longint'(b);
    hi = (a < b) ? longint'(b) : longint'(a);
    if (roll < 3) return coord_t'($urandom_range(0, 65535));
    if (roll < 5) return $urandom_range(0, 1) ? a : b;
    if (roll < 7) begin
      return clamp_coord(($urandom_range(0, 1) ? longint'(a) : longint'(b)) +
                         longint'($urandom_range(0, 16)) - 8);
    end
    if (roll < 9) return coord_t'(lo + longint'($urandom_range(0, hi - lo)));
    return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
  endfunction

  function automatic void queue_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    segment_q.push_back('{sx, sy, ex, ey});
    segments_queued++;
  endfunction

  // Random request shaped around the rectangle the current phase programmed.
  function automatic void queue_random_segment(coord_t l, coord_t b, coord_t r, coord_t t);
    int unsigned roll;
    coord_t sx, sy, ex, ey;
    roll = $urandom_range(0, 9);
    sx = pick_coord(l, r);
    sy = pick_coord(b, t);
    ex = pick_coord(l, r);
    ey = pick_coord(b, t);
    if (roll < 2) begin
      // Plain noise over the whole coordinate range.
      sx = coord_t'($urandom_range(0, 65535));
      sy = coord_t'($urandom_range(0, 65535));
      ex = coord_t'($urandom_range(0, 65535));
      ey = coord_t'($urandom_range(0, 65535));
    end else if (roll == 7) begin
      // Horizontal, on the line of the bottom or the top edge.
      sy = $urandom_range(0, 1) ? b : t;
      ey = sy;
    end else if (roll == 8) begin
      // Vertical, on the line of the left or the right edge.
      sx = $urandom_range(0, 1) ? l : r;
      ex = sx;
    end else if (roll == 9) begin
      // Zero-length segment.
      ex = sx;
      ey = sy;
    end
    queue_segment(sx, sy, ex, ey);
  endfunction

  // ---------------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------------

  // A request stays up with the same payload until it is taken. Once the slot is free,
  // the driver counts down the idle gap, presents the next queued segment, or waits for one.
  always @(posedge clk_i) begin : request_driver
    segment_t seg;
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (segment_q.size() > 0) begin
          seg = segment_q.pop_front();
          in_valid_i <= 1'b1;
          start_x_i <= seg.sx;
          start_y_i <= seg.sy;
          end_x_i <= seg.ex;
          end_y_i <= seg.ey;
          in_gap <= idle_length(in_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // The result side stalls independently of out_valid_o, so stalls hit every stage.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready_i <= 1'b1;
        out_gap <= ($urandom_range(0, 3) == 0) ? idle_length(out_burst) : 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) in_burst <= !in_burst;
    if ($urandom_range(0, 199) == 0) out_burst <= !out_burst;
  end

  // ---------------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------------

  // Register writes, predictions and checks share one block, so a prediction always
  // uses the corners as they stand after every earlier write.
  always @(posedge clk_i) begin : monitor
    segment_t seg;
    bit expected_hit;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_i)
          REG_LEFT:   corner_left <= cfg_data_i;
          REG_BOTTOM: corner_bottom <= cfg_data_i;
          REG_RIGHT:  corner_right <= cfg_data_i;
          REG_TOP:    corner_top <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        seg = '{start_x_i, start_y_i, end_x_i, end_y_i};
        hit_expected_q.push_back(segment_hits_outline(seg));
        segments_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (hit_expected_q.size() == 0) begin
          $error("hit: result with no request outstanding, actual %0b", hit_o);
          fail_count++;
        end else begin
          expected_hit = hit_expected_q.pop_front();
          if (hit_o !== expected_hit) begin
            $error("hit mismatch: expected %0b, actual %0b", expected_hit, hit_o);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Run plan
  // ---------------------------------------------------------------------------------

  // Returns at a rising edge once every queued request has been taken and answered.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (segments_accepted != segments_queued || hit_expected_q.size() != 0);
  endtask

  // Writes all four corners back to back, with a write to an unmapped index slipped
  // in now and then. Must be called right after a rising edge.
  task automatic program_rect(coord_t l, coord_t b, coord_t r, coord_t t);
    reg_write_t writes[$];
    reg_write_t w;
    writes = '{'{REG_LEFT, l}, '{REG_BOTTOM, b}, '{REG_RIGHT, r}, '{REG_TOP, t}};
    if ($urandom_range(0, 2) == 0) begin
      writes.insert($urandom_range(0, 4),
                    '{REG_UNMAPPED + CFG_IDX_W'($urandom_range(0, 3)),
                      coord_t'($urandom_range(0, 65535))});
    end
    foreach (writes[i]) begin
      w = writes[i];
      cfg_valid_i <= 1'b1;
      cfg_idx_i <= w.idx;
      cfg_data_i <= w.data;
      do @(posedge clk_i);
      while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : run_plan
    coord_t l, b, r, t, cx, cy;
    int unsigned kind;

    // The falling edge of the reset clears the block before the first clock.
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corners at reset are all zero, so the outline shrinks to the origin.
    queue_segment(-16'sd100, -16'sd100, 16'sd100, 16'sd100);
    queue_segment(16'sd1, 16'sd0, 16'sd300, 16'sd0);
    queue_segment(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    queue_segment(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    wait_idle();

    // An ordinary rectangle: inside, crossing, corner, collinear and point cases.
    program_rect(-16'sd1000, -16'sd500, 16'sd2000, 16'sd1500);
    queue_segment(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    queue_segment(-16'sd2000, 16'sd0, 16'sd0, 16'sd0);
    queue_segment(-16'sd1100, -16'sd600, -16'sd900, -16'sd400);
    queue_segment(-16'sd3000, -16'sd500, -16'sd500, -16'sd500);
    queue_segment(-16'sd3000, -16'sd500, -16'sd1001, -16'sd500);
    queue_segment(16'sd0, 16'sd1500, 16'sd0, 16'sd1500);
    queue_segment(16'sd5, 16'sd5, 16'sd5, 16'sd5);
    queue_segment(16'sh8000, 16'sd0, 16'sh7fff, 16'sd0);
    queue_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    queue_segment(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    wait_idle();

    // Corners given in the wrong order describe the same outline.
    program_rect(16'sd2000, 16'sd1500, -16'sd1000, -16'sd500);
    queue_segment(16'sd1900, 16'sd0, 16'sd2100, 16'sd10);
    queue_segment(16'sd0, 16'sd0, 16'sd100, 16'sd100);
    queue_segment(-16'sd1000, 16'sd1400, -16'sd1000, 16'sd3000);
    wait_idle();

    // The widest rectangle the coordinates allow.
    program_rect(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    queue_segment(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
    queue_segment(-16'sd300, 16'sd20, 16'sd400, -16'sd90);
    queue_segment(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    wait_idle();

    // A rectangle collapsed to a vertical line.
    program_rect(16'sd100, -16'sd100, 16'sd100, 16'sd100);
    queue_segment(16'sd0, 16'sd0, 16'sd200, 16'sd0);
    queue_segment(16'sd100, 16'sd200, 16'sd100, 16'sd300);
    queue_segment(16'sd100, -16'sd300, 16'sd100, -16'sd100);
    wait_idle();

    // Random phases: a fresh rectangle each time, then a batch of shaped requests.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = (phase == RANDOM_PHASES - 1) ? 2 : $urandom_range(0, 3);
      cx = coord_t'($urandom_range(0, 65535));
      cy = coord_t'($urandom_range(0, 65535));
      case (kind)
        0: begin
          l = coord_t'($urandom_range(0, 65535));
          b = coord_t'($urandom_range(0, 65535));
          r = coord_t'($urandom_range(0, 65535));
          t = coord_t'($urandom_range(0, 65535));
        end
        1: begin
          l = clamp_coord(longint'(cx) - longint'($urandom_range(1, 2000)));
          r = clamp_coord(longint'(cx) + longint'($urandom_range(1, 2000)));
          b = clamp_coord(longint'(cy) - longint'($urandom_range(1, 2000)));
          t = clamp_coord(longint'(cy) + longint'($urandom_range(1, 2000)));
        end
        2: begin
          l = 16'sh7fff;
          b = 16'sh7fff;
          r = 16'sh8000;
          t = 16'sh8000;
        end
        default: begin
          // Mostly degenerate: a vertical or a horizontal line, or else a rectangle with sides of at most 500.
          l = cx;
          b = cy;
          r = $urandom_range(0, 1) ? cx : clamp_coord(longint'(cx) + 500);
          t = (r != cx && $urandom_range(0, 1)) ? cy : clamp_coord(longint'(cy) - 500);
        end
      endcase
      program_rect(l, b, r, t);
      repeat (ITEMS_PER_PHASE) queue_random_segment(l, b, r, t);
      wait_idle();
    end

    // Extra cycles so that a stray result after the last one is still caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
